>>> rtl/core/sorted_list_engine_core_defines.svh
`ifndef SORTED_LIST_ENGINE_CORE_DEFINES_SVH
`define SORTED_LIST_ENGINE_CORE_DEFINES_SVH

// same-cycle implication
`define SLEC_ASSERT_NOW(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error(msg);

// next-cycle implication
`define SLEC_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error(msg);

`endif

>>> rtl/core/slec_pkg.sv
package slec_pkg;

  typedef enum logic [2:0] {
    OP_INSERT  = 3'd0,
    OP_POP_MIN = 3'd1,
    OP_POP_MAX = 3'd2,
    OP_READ    = 3'd3,
    OP_CLEAR   = 3'd4
  } op_t;

  localparam int VALUE_W = 32;
  localparam int POS_W   = 6;
  localparam int ELEM_W  = 7;

  typedef struct packed {
    logic [2:0]                op;
    logic signed [VALUE_W-1:0] new_value;
    logic [POS_W-1:0]          position;
  } req_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] result_value;
    logic                      ok;
    logic [ELEM_W-1:0]         elem_count;
  } rsp_t;

  typedef struct packed {
    logic                      do_insert;
    logic                      do_shift;
    logic signed [VALUE_W-1:0] new_value;
  } cell_ctl_t;

endpackage

>>> rtl/core/slec_cell.sv
module slec_cell #(
  parameter int IDX_W = 6,
  parameter int IDX   = 0
) (
  input  logic                               clk,
  input  slec_pkg::cell_ctl_t                ctl,
  input  logic [IDX_W-1:0]                   sel,
  input  logic                               valid,
  input  logic                               left_mark,
  input  logic signed [slec_pkg::VALUE_W-1:0] left_val,
  input  logic signed [slec_pkg::VALUE_W-1:0] right_val,
  output logic                               mark,
  output logic signed [slec_pkg::VALUE_W-1:0] val,
  output logic signed [slec_pkg::VALUE_W-1:0] rd_val
);
  import slec_pkg::*;

  logic signed [VALUE_W-1:0] val_next;

  // empty cells count as greater so the insert slot is the first marked cell
  assign mark = !valid || (val > ctl.new_value);

  always_comb begin
    val_next = val;
    if (ctl.do_insert) begin
      if (left_mark) begin
        val_next = left_val;
      end else if (mark) begin
        val_next = ctl.new_value;
      end
    end else if (ctl.do_shift) begin
      val_next = right_val;
    end
  end

  always_ff @(posedge clk) begin
    val <= val_next;
  end

  assign rd_val = (sel == IDX_W'(IDX)) ? val : '0;

endmodule

>>> rtl/core/sorted_list_engine_core.sv
// channel   | ports                              | direction
// request   | start, busy, request               | in, accepted at start && !busy
// response  | response_valid, response           | out, one cycle, cannot be held off
//
// Cells update as a request is accepted; its response is valid in the cycle after.
// A new request may be taken every cycle: every cell shifts, loads or holds in that cycle.
// busy is high only during reset; the list comes out of reset empty.
// Reads and pops select one cell through a one-hot OR across the chain.
`include "sorted_list_engine_core_defines.svh"

module sorted_list_engine_core #(
  parameter int CAPACITY = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  slec_pkg::req_t request,
  output logic           response_valid,
  output slec_pkg::rsp_t response
);
  import slec_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;
  logic               accept;
  cell_ctl_t          ctl;
  logic [IDX_W-1:0]   sel;
  logic               ok;
  logic               ret_val;
  logic               rsp_ok;
  logic signed [VALUE_W-1:0] rsp_value;
  logic signed [VALUE_W-1:0] rd_or;

  logic                      marks  [CAPACITY];
  logic signed [VALUE_W-1:0] vals   [CAPACITY];
  logic signed [VALUE_W-1:0] rd_vals[CAPACITY];

  assign busy   = rst;
  assign accept = start && !busy;

  always_comb begin
    count_next    = count;
    ctl.do_insert = 1'b0;
    ctl.do_shift  = 1'b0;
    ctl.new_value = request.new_value;
    sel           = '0;
    ok            = 1'b0;
    ret_val       = 1'b0;
    case (request.op)
      OP_INSERT: begin
        if (count < CNT_W'(CAPACITY)) begin
          ctl.do_insert = accept;
          count_next    = count + 1'b1;
          ok            = 1'b1;
        end
      end
      OP_POP_MIN: begin
        if (count != '0) begin
          ctl.do_shift = accept;
          count_next   = count - 1'b1;
          ok           = 1'b1;
          ret_val      = 1'b1;
        end
      end
      OP_POP_MAX: begin
        sel = IDX_W'(count - 1'b1);
        if (count != '0) begin
          count_next = count - 1'b1;
          ok         = 1'b1;
          ret_val    = 1'b1;
        end
      end
      OP_READ: begin
        sel = IDX_W'(request.position);
        if (CMP_W'(request.position) < CMP_W'(count)) begin
          ok      = 1'b1;
          ret_val = 1'b1;
        end
      end
      OP_CLEAR: begin
        count_next = '0;
        ok         = 1'b1;
      end
      default: begin
      end
    endcase
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    slec_cell #(
      .IDX_W(IDX_W),
      .IDX  (i)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .sel      (sel),
      .valid    (CNT_W'(i) < count),
      .left_mark((i == 0) ? 1'b0 : marks[(i == 0) ? 0 : i - 1]),
      .left_val (vals[(i == 0) ? 0 : i - 1]),
      .right_val(vals[(i == CAPACITY - 1) ? i : i + 1]),
      .mark     (marks[i]),
      .val      (vals[i]),
      .rd_val   (rd_vals[i])
    );
  end

  always_comb begin
    rd_or = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_or = rd_or | rd_vals[i];
    end
  end

  assign rsp_ok    = ok;
  assign rsp_value = ret_val ? rd_or : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      count          <= '0;
      response_valid <= 1'b0;
    end else begin
      response_valid <= accept;
      if (accept) begin
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      response.result_value <= rsp_value;
      response.ok           <= rsp_ok;
      response.elem_count   <= ELEM_W'(count_next);
    end
  end

  `SLEC_ASSERT_NOW(a_count_bound, 1'b1, count <= CNT_W'(CAPACITY), "count above capacity")
  `SLEC_ASSERT_NEXT(a_rsp_follows, accept, response_valid, "request without response")
  `SLEC_ASSERT_NEXT(a_no_extra_rsp, !accept, !response_valid, "response without request")
  `SLEC_ASSERT_NOW(a_fail_zero, response_valid && !response.ok,
                   response.result_value == '0, "failed response carries a value")
  `SLEC_ASSERT_NEXT(a_insert_count,
                    accept && request.op == OP_INSERT && count < CNT_W'(CAPACITY),
                    count == $past(count) + 1'b1, "insert did not grow the list")

endmodule

>>> dv/tb_sorted_list_engine_core.sv
module tb_sorted_list_engine_core;
  timeunit 1ns;
  timeprecision 1ps;

  import slec_pkg::*;

  localparam int CAPACITY    = 64;
  localparam int RANDOM_REQS = 2000;
  localparam int CYCLE_LIMIT = 200000;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  req_t request;
  logic response_valid;
  rsp_t response;

  sorted_list_engine_core #(
    .CAPACITY(CAPACITY)
  ) i_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .request       (request),
    .response_valid(response_valid),
    .response      (response)
  );

  logic signed [VALUE_W-1:0] list_vals[$];
  rsp_t                      pending_rsp[$];

  int  errors;
  int  cycles;
  int  sent;
  int  checked;
  int  peak_count;
  int  refused_inserts;
  int  burst_left;
  bit  allow_gaps;

  initial begin
    clk = 1'b0;
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // sorted-list behavior: one response per request
  function automatic rsp_t apply_request(req_t r);
    rsp_t rsp;
    int   slot;
    rsp = '0;
    case (r.op)
      OP_INSERT: begin
        if (list_vals.size() < CAPACITY) begin
          slot = 0;
          while (slot < list_vals.size() && !(list_vals[slot] > r.new_value)) slot++;
          list_vals.insert(slot, r.new_value);
          rsp.ok = 1'b1;
        end else begin
          refused_inserts++;
        end
      end
      OP_POP_MIN: begin
        if (list_vals.size() > 0) begin
          rsp.result_value = list_vals.pop_front();
          rsp.ok = 1'b1;
        end
      end
      OP_POP_MAX: begin
        if (list_vals.size() > 0) begin
          rsp.result_value = list_vals.pop_back();
          rsp.ok = 1'b1;
        end
      end
      OP_READ: begin
        if (int'(r.position) < list_vals.size()) begin
          rsp.result_value = list_vals[r.position];
          rsp.ok = 1'b1;
        end
      end
      OP_CLEAR: begin
        list_vals.delete();
        rsp.ok = 1'b1;
      end
      default: ;
    endcase
    rsp.elem_count = ELEM_W'(list_vals.size());
    if (list_vals.size() > peak_count) peak_count = list_vals.size();
    return rsp;
  endfunction

  function automatic req_t make_req(op_t op, logic signed [VALUE_W-1:0] v,
                                    logic [POS_W-1:0] p);
    req_t r;
    r.op        = op;
    r.new_value = v;
    r.position  = p;
    return r;
  endfunction

  function automatic logic signed [VALUE_W-1:0] rand_value();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) return $urandom;
    if (pick < 70) return $signed($urandom_range(0, 15)) - 8;
    if (pick < 80) begin
      case ($urandom_range(0, 3))
        0: return 32'sh8000_0000;
        1: return 32'sh7fff_ffff;
        2: return 0;
        default: return -1;
      endcase
    end
    if (list_vals.size() > 0) return list_vals[$urandom_range(0, list_vals.size() - 1)];
    return $urandom;
  endfunction

  function automatic logic [POS_W-1:0] rand_position();
    if (list_vals.size() > 0 && $urandom_range(0, 99) < 75)
      return POS_W'($urandom_range(0, list_vals.size() - 1));
    return POS_W'($urandom);
  endfunction

  function automatic req_t rand_req(int ins_pct, int pop_pct);
    req_t r;
    int   pick;
    r = make_req(OP_READ, rand_value(), rand_position());
    pick = $urandom_range(0, 99);
    if (pick < ins_pct) begin
      r.op = OP_INSERT;
    end else if (pick < ins_pct + pop_pct) begin
      r.op = $urandom_range(0, 1) ? OP_POP_MIN : OP_POP_MAX;
    end else if (pick < 96) begin
      r.op = OP_READ;
    end else if (pick < 97) begin
      r.op = OP_CLEAR;
    end else begin
      r.op = 3'($urandom_range(int'(OP_CLEAR) + 1, 7));
    end
    return r;
  endfunction

  task automatic idle_gap();
    repeat ($urandom_range(1, 5)) begin
      @(negedge clk);
      start   <= 1'b0;
      request <= make_req(op_t'($urandom_range(0, 7)), $urandom, POS_W'($urandom));
    end
  endtask

  task automatic send_request(req_t r);
    if (allow_gaps && burst_left == 0) begin
      idle_gap();
      burst_left = $urandom_range(1, 16);
    end
    @(negedge clk);
    start   <= 1'b1;
    request <= r;
    do @(posedge clk); while (busy);
    pending_rsp.push_back(apply_request(r));
    sent++;
    if (burst_left > 0) burst_left--;
  endtask

  task automatic test_empty_list();
    send_request(make_req(OP_POP_MIN, 0, 0));
    send_request(make_req(OP_POP_MAX, 0, 0));
    send_request(make_req(OP_READ, 0, 0));
    send_request(make_req(OP_CLEAR, 0, 0));
    for (int c = int'(OP_CLEAR) + 1; c < 8; c++)
      send_request(make_req(op_t'(c), 32'sh7fff_ffff, '1));
  endtask

  task automatic test_extremes();
    send_request(make_req(OP_INSERT, 32'sh7fff_ffff, 0));
    send_request(make_req(OP_INSERT, 32'sh8000_0000, 0));
    send_request(make_req(OP_INSERT, 0, 0));
    send_request(make_req(OP_INSERT, -1, 0));
    send_request(make_req(OP_INSERT, -1, 0));
    send_request(make_req(OP_INSERT, 32'sh8000_0000, 0));
    for (int p = 0; p < 7; p++) send_request(make_req(OP_READ, 0, POS_W'(p)));
    send_request(make_req(OP_READ, 0, '1));
    send_request(make_req(OP_POP_MIN, 0, 0));
    send_request(make_req(OP_POP_MAX, 0, 0));
    send_request(make_req(OP_READ, 0, 0));
    send_request(make_req(OP_CLEAR, 0, 0));
    send_request(make_req(OP_READ, 0, 0));
  endtask

  task automatic test_full_list();
    send_request(make_req(OP_CLEAR, 0, 0));
    repeat (CAPACITY) send_request(make_req(OP_INSERT, rand_value(), 0));
    send_request(make_req(OP_INSERT, 32'sh7fff_ffff, 0));
    send_request(make_req(OP_INSERT, 32'sh8000_0000, 0));
    send_request(make_req(OP_READ, 0, '1));
    send_request(make_req(OP_READ, 0, 0));
    send_request(make_req(op_t'(int'(OP_CLEAR) + 1), 0, 0));
    send_request(make_req(OP_POP_MAX, 0, 0));
    send_request(make_req(OP_READ, 0, '1));
    send_request(make_req(OP_INSERT, $urandom, 0));
    send_request(make_req(OP_POP_MIN, 0, 0));
    send_request(make_req(OP_CLEAR, 0, 0));
  endtask

  task automatic test_random_mix();
    int done;
    int len;
    int ins_pct;
    int pop_pct;
    done = 0;
    while (done < RANDOM_REQS) begin
      case ($urandom_range(0, 2))
        0: begin ins_pct = 70; pop_pct = 10; end
        1: begin ins_pct = 10; pop_pct = 70; end
        default: begin ins_pct = 40; pop_pct = 40; end
      endcase
      allow_gaps = ($urandom_range(0, 3) != 0);
      len = $urandom_range(40, 150);
      repeat (len) send_request(rand_req(ins_pct, pop_pct));
      done += len;
    end
  endtask

  always @(posedge clk) begin : check_response
    rsp_t want;
    if (!rst && response_valid) begin
      if (pending_rsp.size() == 0) begin
        $display("%0t: response with none pending: value %0d ok %0b count %0d", $time,
                 response.result_value, response.ok, response.elem_count);
        errors++;
      end else begin
        want = pending_rsp.pop_front();
        checked++;
        if (response.result_value !== want.result_value) begin
          $display("%0t: result_value expected %0d got %0d", $time,
                   want.result_value, response.result_value);
          errors++;
        end
        if (response.ok !== want.ok) begin
          $display("%0t: ok expected %0b got %0b", $time, want.ok, response.ok);
          errors++;
        end
        if (response.elem_count !== want.elem_count) begin
          $display("%0t: elem_count expected %0d got %0d", $time,
                   want.elem_count, response.elem_count);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d responses pending", $time, pending_rsp.size());
      $display("[sorted_list_engine_core] ERROR");
      $finish;
    end
  end

  initial begin
    rst        = 1'b1;
    start      = 1'b0;
    request    = '0;
    errors     = 0;
    cycles     = 0;
    sent       = 0;
    checked    = 0;
    peak_count = 0;
    refused_inserts = 0;
    burst_left = 0;
    allow_gaps = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_list();
    test_extremes();
    allow_gaps = 1'b1;
    test_full_list();
    test_random_mix();

    @(negedge clk);
    start <= 1'b0;
    wait (pending_rsp.size() == 0);
    repeat (5) @(posedge clk);

    $display("%0d requests sent, %0d responses checked", sent, checked);
    $display("peak list size %0d of %0d, %0d inserts refused on a full list",
             peak_count, CAPACITY, refused_inserts);
    if (errors == 0) begin
      $display("[sorted_list_engine_core] OK");
    end else begin
      $display("[sorted_list_engine_core] ERROR");
    end
    $finish;
  end

endmodule
